/* sv/ssps_pkg.sv */
// Shared types and constants for the servo slew and pulse sequencer.
package ssps_pkg;

    localparam int NSERVO         = 5;
    localparam int IDX_BITS       = 3;
    localparam int FIELD_BITS     = 16;
    localparam int WIDTH_BITS_DEF = 16;

    localparam int KNOB_A_STEP = 40;
    localparam int KNOB_A_BAND = 40;
    localparam int KNOB_B_STEP = 10;
    localparam int KNOB_B_BAND = 20;
    localparam int HOME_STEP   = 10;
    localparam int HOME_BAND   = 10;

    localparam logic [FIELD_BITS-1:0] SAFE_RESET  = 16'd4688;
    localparam logic [FIELD_BITS-1:0] FRAME_RESET = 16'd62500;

    localparam logic [IDX_BITS-1:0] LAST_SERVO = 3'd4;
    localparam logic [IDX_BITS-1:0] LAST_SLOT  = 3'd5;
    localparam logic [IDX_BITS-1:0] ALL_REACHED = 3'd5;

    typedef enum logic [1:0] {
        CMD_SLEW       = 2'd0,
        CMD_SLOT_END   = 2'd1,
        CMD_LOAD_KNOBS = 2'd2,
        CMD_HOME       = 2'd3
    } t_cmd;

    localparam logic [2:0] CFG_SAFE_1 = 3'd0;
    localparam logic [2:0] CFG_SAFE_2 = 3'd1;
    localparam logic [2:0] CFG_SAFE_3 = 3'd2;
    localparam logic [2:0] CFG_SAFE_4 = 3'd3;
    localparam logic [2:0] CFG_SAFE_5 = 3'd4;
    localparam logic [2:0] CFG_FRAME  = 3'd5;

    typedef struct packed {
        t_cmd                  cmd;
        logic [FIELD_BITS-1:0] target_a;
        logic [FIELD_BITS-1:0] target_b;
    } t_in_item;

    typedef struct packed {
        logic [NSERVO-1:0]     pin_select;
        logic [FIELD_BITS-1:0] slot_length;
        logic                  homing_done;
        logic                  knobs_settled;
    } t_out_item;

endpackage

/* sv/ssps_approach.sv */
// Moves one servo width a fixed step toward a target when outside a deadband.
module ssps_approach #(
    parameter int W    = ssps_pkg::WIDTH_BITS_DEF,
    parameter int STEP = ssps_pkg::HOME_STEP,
    parameter int BAND = ssps_pkg::HOME_BAND
) (
    input  logic [W-1:0]                    i_width,
    input  logic [ssps_pkg::FIELD_BITS-1:0] i_target,
    output logic [W-1:0]                    o_width,
    output logic                            o_inside
);

    // One extra bit keeps the band additions from wrapping.
    localparam int CW = ((W > ssps_pkg::FIELD_BITS) ? W : ssps_pkg::FIELD_BITS) + 1;

    logic [CW-1:0] w_ext;
    logic [CW-1:0] t_ext;
    logic          above;
    logic          below;

    assign w_ext = CW'(i_width);
    assign t_ext = CW'(i_target);
    assign above = w_ext > (t_ext + CW'(BAND));
    assign below = (w_ext + CW'(BAND)) < t_ext;

    always_comb begin
        o_inside = 1'b0;
        if (above) begin
            o_width = i_width - W'(STEP);
        end else if (below) begin
            o_width = i_width + W'(STEP);
        end else begin
            o_width  = i_width;
            o_inside = 1'b1;
        end
    end

endmodule

/* sv/servo_slew_and_pulse_sequencer_top.sv */
// Servo slew and pulse sequencer: five slewed servo widths and a six-slot pulse frame.
// One command is taken per clock cycle while the input is not stalled. Each command passes
// through an input register, is applied to the servo state by combinational
// compare-and-add logic, and its result sits in an output register. While a
// finished result waits to be taken, one more command can be transferred into the
// input register; after that the input stalls until the result leaves. A slew tick
// moves one knob-driven servo while the knob pair is unsettled and, while
// homing, one more servo toward its safe width; a slot-end command returns the
// pin and length of the slot just begun, where the gap slot lasts the frame
// length minus the widths sent in the previous frame, floored at zero. The user
// must write safe widths and frame length through the configuration port only while no
// command is in flight; the block itself does not enforce this. WIDTH_BITS sets the
// internal servo width precision.
module servo_slew_and_pulse_sequencer_top #(
    parameter int WIDTH_BITS = ssps_pkg::WIDTH_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  ssps_pkg::t_in_item              i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ssps_pkg::t_out_item             o_out,
    input  logic                            i_cfg_we,
    input  logic [2:0]                      i_cfg_idx,
    input  logic [ssps_pkg::FIELD_BITS-1:0] i_cfg_data
);

    localparam int W  = WIDTH_BITS;
    localparam int SW = W + 3;
    localparam int GW = (SW > ssps_pkg::FIELD_BITS) ? SW : ssps_pkg::FIELD_BITS;
    localparam int N  = ssps_pkg::NSERVO;
    localparam int IB = ssps_pkg::IDX_BITS;
    localparam int FB = ssps_pkg::FIELD_BITS;

    // Handshake and payload registers.
    logic                r_in_valid;
    ssps_pkg::t_in_item  r_in;
    logic                r_out_valid;
    ssps_pkg::t_out_item r_out;
    ssps_pkg::t_out_item n_out;
    logic                w_go;
    logic                w_take;

    // Configuration.
    logic [FB-1:0] r_safe [N];
    logic [FB-1:0] r_frame;

    // Servo state.
    logic [W-1:0]  r_width [N];
    logic [W-1:0]  n_width [N];
    logic [FB-1:0] r_knob_tgt [2];
    logic [FB-1:0] n_knob_tgt [2];
    logic          r_knob_phase, n_knob_phase;
    logic          r_settled, n_settled;
    logic          r_home_act, n_home_act;
    logic [IB-1:0] r_home_phase, n_home_phase;
    logic [N-1:0]  r_reached_marks, n_reached_marks;
    logic [IB-1:0] r_reached_cnt, n_reached_cnt;
    logic [IB-1:0] r_pulse_slot, n_pulse_slot;
    logic [SW-1:0] r_width_sum, n_width_sum;

    // Datapath.
    logic [W-1:0]  knob_a_w, knob_b_w, home_in, home_w, rd_width;
    logic          knob_a_in, knob_b_in, home_inside;
    logic [IB-1:0] home_idx, slot_idx, slot_m1, rd_idx;
    logic          knob_act;
    logic [GW-1:0] frame_ext, sum_ext, gap;
    logic [IB-1:0] cnt_inc;

    assign w_go       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign w_take     = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_go) begin
                r_in_valid <= 1'b0;
            end
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= i_in;
        end
        if (w_go) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_safe[i] <= ssps_pkg::SAFE_RESET;
            end
            r_frame <= ssps_pkg::FRAME_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ssps_pkg::CFG_SAFE_1: r_safe[0] <= i_cfg_data;
                ssps_pkg::CFG_SAFE_2: r_safe[1] <= i_cfg_data;
                ssps_pkg::CFG_SAFE_3: r_safe[2] <= i_cfg_data;
                ssps_pkg::CFG_SAFE_4: r_safe[3] <= i_cfg_data;
                ssps_pkg::CFG_SAFE_5: r_safe[4] <= i_cfg_data;
                ssps_pkg::CFG_FRAME:  r_frame   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Knob servos always read their own fixed entries.
    ssps_approach #(
        .W(W), .STEP(ssps_pkg::KNOB_A_STEP), .BAND(ssps_pkg::KNOB_A_BAND)
    ) u_knob_a (
        .i_width (r_width[0]),
        .i_target(r_knob_tgt[0]),
        .o_width (knob_a_w),
        .o_inside(knob_a_in)
    );

    ssps_approach #(
        .W(W), .STEP(ssps_pkg::KNOB_B_STEP), .BAND(ssps_pkg::KNOB_B_BAND)
    ) u_knob_b (
        .i_width (r_width[1]),
        .i_target(r_knob_tgt[1]),
        .o_width (knob_b_w),
        .o_inside(knob_b_in)
    );

    assign knob_act = (r_in.cmd == ssps_pkg::CMD_SLEW) && !r_settled;
    assign home_idx = (r_home_phase > ssps_pkg::LAST_SERVO) ? '0 : r_home_phase;
    assign slot_idx = (r_pulse_slot > ssps_pkg::LAST_SLOT) ? '0 : r_pulse_slot;
    assign slot_m1  = slot_idx - IB'(1);

    // Slew ticks and slot ends never coincide, so one read port serves both.
    assign rd_idx   = (r_in.cmd == ssps_pkg::CMD_SLOT_END) ? slot_m1 : home_idx;
    assign rd_width = r_width[rd_idx];

    // The homing step sees a width the knob slew changed in the same tick.
    always_comb begin
        home_in = rd_width;
        if (knob_act && !r_knob_phase && home_idx == IB'(0)) begin
            home_in = knob_a_w;
        end else if (knob_act && r_knob_phase && home_idx == IB'(1)) begin
            home_in = knob_b_w;
        end
    end

    ssps_approach #(
        .W(W), .STEP(ssps_pkg::HOME_STEP), .BAND(ssps_pkg::HOME_BAND)
    ) u_home (
        .i_width (home_in),
        .i_target(r_safe[home_idx]),
        .o_width (home_w),
        .o_inside(home_inside)
    );

    assign frame_ext = GW'(r_frame);
    assign sum_ext   = GW'(r_width_sum);
    assign gap       = (frame_ext > sum_ext) ? (frame_ext - sum_ext) : '0;
    assign cnt_inc   = r_reached_cnt + IB'(1);

    always_comb begin
        for (int i = 0; i < N; i++) begin
            n_width[i] = r_width[i];
        end
        n_knob_tgt      = r_knob_tgt;
        n_knob_phase    = r_knob_phase;
        n_settled       = r_settled;
        n_home_act      = r_home_act;
        n_home_phase    = r_home_phase;
        n_reached_marks = r_reached_marks;
        n_reached_cnt   = r_reached_cnt;
        n_pulse_slot    = r_pulse_slot;
        n_width_sum     = r_width_sum;
        n_out           = '0;

        unique case (r_in.cmd)
            ssps_pkg::CMD_SLEW: begin
                if (knob_act) begin
                    if (!r_knob_phase) begin
                        n_width[0] = knob_a_w;
                    end else begin
                        n_width[1] = knob_b_w;
                        if (knob_b_in) begin
                            n_settled = 1'b1;
                        end
                    end
                    n_knob_phase = ~r_knob_phase;
                end
                if (r_home_act) begin
                    n_width[home_idx] = home_w;
                    if (home_inside && !r_reached_marks[home_idx]) begin
                        n_reached_marks[home_idx] = 1'b1;
                        n_reached_cnt             = cnt_inc;
                    end
                    if (home_idx == ssps_pkg::LAST_SERVO) begin
                        if (n_reached_cnt == ssps_pkg::ALL_REACHED) begin
                            n_home_act          = 1'b0;
                            n_reached_cnt       = '0;
                            n_reached_marks     = '0;
                            n_out.homing_done   = 1'b1;
                        end
                        n_home_phase = '0;
                    end else begin
                        n_home_phase = home_idx + IB'(1);
                    end
                end
            end
            ssps_pkg::CMD_SLOT_END: begin
                if (slot_idx == IB'(0)) begin
                    n_out.slot_length = FB'(gap);
                    n_pulse_slot      = IB'(1);
                end else begin
                    n_out.pin_select  = N'(1) << slot_m1;
                    n_out.slot_length = FB'(rd_width);
                    n_width_sum       = (slot_idx == IB'(1)) ? SW'(rd_width)
                                                             : r_width_sum + SW'(rd_width);
                    n_pulse_slot      = (slot_idx == ssps_pkg::LAST_SLOT) ? '0
                                                                          : slot_idx + IB'(1);
                end
            end
            ssps_pkg::CMD_LOAD_KNOBS: begin
                n_knob_tgt[0] = r_in.target_a;
                n_knob_tgt[1] = r_in.target_b;
                n_settled     = 1'b0;
            end
            ssps_pkg::CMD_HOME: begin
                n_home_act = 1'b1;
            end
        endcase

        n_out.knobs_settled = n_settled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_width[i] <= '0;
            end
            r_knob_tgt[0]   <= '0;
            r_knob_tgt[1]   <= '0;
            r_knob_phase    <= 1'b0;
            r_settled       <= 1'b1;
            r_home_act      <= 1'b0;
            r_home_phase    <= '0;
            r_reached_marks <= '0;
            r_reached_cnt   <= '0;
            r_pulse_slot    <= '0;
            r_width_sum     <= '0;
        end else if (w_go) begin
            r_width         <= n_width;
            r_knob_tgt      <= n_knob_tgt;
            r_knob_phase    <= n_knob_phase;
            r_settled       <= n_settled;
            r_home_act      <= n_home_act;
            r_home_phase    <= n_home_phase;
            r_reached_marks <= n_reached_marks;
            r_reached_cnt   <= n_reached_cnt;
            r_pulse_slot    <= n_pulse_slot;
            r_width_sum     <= n_width_sum;
        end
    end

    // The reached count must always agree with the marks it summarizes.
    a_count_matches_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_reached_cnt) == $countones(r_reached_marks))
        else $error("reached count out of step with reached marks");

    a_phases_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_home_phase <= ssps_pkg::LAST_SERVO && r_pulse_slot <= ssps_pkg::LAST_SLOT)
        else $error("sequencer phase left its range");

    a_done_clears_homing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && n_out.homing_done) |=> (!r_home_act && r_reached_marks == '0))
        else $error("homing still active after done");

    a_pins_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0(r_out.pin_select))
        else $error("more than one servo pin selected");

    a_no_done_without_homing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && n_out.homing_done) |-> r_home_act)
        else $error("done reported while homing was idle");

endmodule

/* sim/tb.sv */
// Self-checking testbench for the servo slew and pulse sequencer.
module tb;

    localparam int FIELD_BITS   = ssps_pkg::FIELD_BITS;
    localparam int NSERVO       = ssps_pkg::NSERVO;
    localparam int FIELD_MAX    = (1 << FIELD_BITS) - 1;
    localparam int RANDOM_ITEMS = 1000;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    ssps_pkg::t_in_item    i_in        = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [2:0]            i_cfg_idx   = ssps_pkg::CFG_SAFE_1;
    logic [FIELD_BITS-1:0] i_cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    ssps_pkg::t_out_item   o_out;

    // Predicted block state, starting from its reset values.
    logic [FIELD_BITS-1:0] pulse_w [NSERVO] = '{default: '0};
    logic [FIELD_BITS-1:0] knob_goal [2]    = '{default: '0};
    logic                  knob_turn        = 1'b0;
    logic                  pair_settled     = 1'b1;
    logic                  homing_on        = 1'b0;
    int                    home_turn        = 0;
    logic [NSERVO-1:0]     home_reached     = '0;
    int                    home_count       = 0;
    int                    slot_idx         = 0;
    logic [FIELD_BITS+2:0] last_frame_sum   = '0;
    logic [FIELD_BITS-1:0] safe_w [NSERVO]  = '{default: ssps_pkg::SAFE_RESET};
    logic [FIELD_BITS-1:0] frame_w          = ssps_pkg::FRAME_RESET;

    ssps_pkg::t_out_item pending_results [$];
    int          failures           = 0;
    int          results_checked    = 0;
    int          items_sent         = 0;
    int          settings_used      = 1;
    int          homing_completions = 0;
    int          gap_slots          = 0;
    int          burst_left         = 5;
    t_stall_mode stall_mode         = STALL_NONE;
    logic [6:0]  stall_clock        = '0;

    servo_slew_and_pulse_sequencer_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Moves w by step toward t unless it is already within band of it.
    function automatic logic [FIELD_BITS-1:0] slew_toward(input logic [FIELD_BITS-1:0] w,
                                                          input logic [FIELD_BITS-1:0] t,
                                                          input int step, input int band,
                                                          output logic in_band);
        in_band = 1'b0;
        if (int'(w) > int'(t) + band) return w - FIELD_BITS'(step);
        if (int'(w) + band < int'(t)) return w + FIELD_BITS'(step);
        in_band = 1'b1;
        return w;
    endfunction

    function automatic ssps_pkg::t_out_item predict_sequencer_result(
        input ssps_pkg::t_in_item item);
        ssps_pkg::t_out_item   res;
        logic                  in_band;
        logic [FIELD_BITS-1:0] w;
        int                    p;
        int                    s;
        res = '0;
        case (item.cmd)
            ssps_pkg::CMD_SLEW: begin
                if (!pair_settled) begin
                    if (!knob_turn) begin
                        pulse_w[0] = slew_toward(pulse_w[0], knob_goal[0],
                                                 ssps_pkg::KNOB_A_STEP,
                                                 ssps_pkg::KNOB_A_BAND, in_band);
                        knob_turn = 1'b1;
                    end else begin
                        pulse_w[1] = slew_toward(pulse_w[1], knob_goal[1],
                                                 ssps_pkg::KNOB_B_STEP,
                                                 ssps_pkg::KNOB_B_BAND, in_band);
                        if (in_band) pair_settled = 1'b1;
                        knob_turn = 1'b0;
                    end
                end
                if (homing_on) begin
                    p = (home_turn >= NSERVO) ? 0 : home_turn;
                    pulse_w[p] = slew_toward(pulse_w[p], safe_w[p], ssps_pkg::HOME_STEP,
                                             ssps_pkg::HOME_BAND, in_band);
                    // A servo counts only the first time it comes within the band.
                    if (in_band && !home_reached[p]) begin
                        home_reached[p] = 1'b1;
                        home_count = (home_count + 1) % 8;
                    end
                    if (p == NSERVO - 1) begin
                        if (home_count == NSERVO) begin
                            homing_on    = 1'b0;
                            home_count   = 0;
                            home_reached = '0;
                            res.homing_done = 1'b1;
                        end
                        home_turn = 0;
                    end else begin
                        home_turn = p + 1;
                    end
                end
            end
            ssps_pkg::CMD_SLOT_END: begin
                s = (slot_idx > NSERVO) ? 0 : slot_idx;
                if (s == 0) begin
                    // The gap fills what the previous frame's pulses left over.
                    res.slot_length = (frame_w > last_frame_sum) ?
                                      FIELD_BITS'(frame_w - last_frame_sum) : '0;
                    slot_idx = 1;
                end else begin
                    w = pulse_w[s - 1];
                    res.pin_select  = NSERVO'(1 << (s - 1));
                    res.slot_length = w;
                    last_frame_sum  = (s == 1) ? (FIELD_BITS + 3)'(w) : last_frame_sum + w;
                    slot_idx = (s == NSERVO) ? 0 : s + 1;
                end
            end
            ssps_pkg::CMD_LOAD_KNOBS: begin
                knob_goal[0] = item.target_a;
                knob_goal[1] = item.target_b;
                pair_settled = 1'b0;
            end
            default: homing_on = 1'b1;
        endcase
        res.knobs_settled = pair_settled;
        return res;
    endfunction

    task automatic report_failure(input string msg);
        failures++;
        if (failures <= 10) $display("ERROR at %0t: %s", $time, msg);
    endtask

    // Predicts on every input transfer and checks every output transfer.
    always @(posedge i_clk) begin : scoreboard
        ssps_pkg::t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                want = predict_sequencer_result(i_in);
                pending_results.push_back(want);
                if (i_in.cmd == ssps_pkg::CMD_SLOT_END && want.pin_select == '0) gap_slots++;
                if (want.homing_done) homing_completions++;
            end
            if (o_out_valid && !i_out_stall) begin
                results_checked++;
                if (pending_results.size() == 0) begin
                    report_failure("result arrived with nothing expected");
                end else begin
                    want = pending_results.pop_front();
                    if (o_out.pin_select !== want.pin_select ||
                        o_out.slot_length !== want.slot_length ||
                        o_out.homing_done !== want.homing_done ||
                        o_out.knobs_settled !== want.knobs_settled) begin
                        report_failure($sformatf(
                            {"expected pins=%b len=%0d done=%b settled=%b, ",
                             "got pins=%b len=%0d done=%b settled=%b"},
                            want.pin_select, want.slot_length, want.homing_done,
                            want.knobs_settled, o_out.pin_select, o_out.slot_length,
                            o_out.homing_done, o_out.knobs_settled));
                    end
                end
            end
        end
    end

    // The receiver picks a stall style at random each time its 7-bit stall clock wraps to zero.
    always @(posedge i_clk) begin
        stall_clock <= stall_clock + 1'b1;
        if (stall_clock == '0) stall_mode <= t_stall_mode'($urandom_range(0, 3));
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= (stall_clock[3:0] < 4'd7);
        endcase
    end

    function automatic ssps_pkg::t_in_item make_command(input ssps_pkg::t_cmd c,
                                                        input logic [FIELD_BITS-1:0] a,
                                                        input logic [FIELD_BITS-1:0] b);
        ssps_pkg::t_in_item item;
        item.cmd      = c;
        item.target_a = a;
        item.target_b = b;
        return item;
    endfunction

    function automatic logic [FIELD_BITS-1:0] near_value(input int base, input int span);
        int v;
        v = base + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0) v = 0;
        if (v > FIELD_MAX) v = FIELD_MAX;
        return FIELD_BITS'(v);
    endfunction

    // Holds the item until its transfer, then idles between bursts.
    task automatic send_command(input ssps_pkg::t_in_item item);
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
    endtask

    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Index r of vals goes to register r; write enable stays high through all six.
    task automatic program_registers(
        input logic [ssps_pkg::CFG_FRAME:0][FIELD_BITS-1:0] vals);
        int r;
        for (r = ssps_pkg::CFG_SAFE_1; r <= ssps_pkg::CFG_FRAME; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 3'(r);
            i_cfg_data <= vals[r];
            @(posedge i_clk);
            if (r == ssps_pkg::CFG_FRAME) frame_w = vals[r];
            else safe_w[r] = vals[r];
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic ssps_pkg::t_in_item random_command();
        ssps_pkg::t_in_item item;
        int                 roll;
        item.target_a = FIELD_BITS'($urandom);
        item.target_b = FIELD_BITS'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            item.cmd = ssps_pkg::CMD_SLEW;
        end else if (roll < 75) begin
            item.cmd = ssps_pkg::CMD_SLOT_END;
        end else if (roll < 90) begin
            item.cmd = ssps_pkg::CMD_LOAD_KNOBS;
            // Mostly nearby targets so the pair settles; the rest keep random bits.
            if ($urandom_range(0, 3) != 0) begin
                item.target_a = near_value(pulse_w[0], 300);
                item.target_b = near_value(pulse_w[1], 100);
            end
        end else begin
            item.cmd = ssps_pkg::CMD_HOME;
        end
        return item;
    endfunction

    task automatic test_reset_frame();
        send_command(make_command(ssps_pkg::CMD_SLEW, FIELD_BITS'($urandom),
                                  FIELD_BITS'($urandom)));
        repeat (NSERVO + 1) send_command(make_command(ssps_pkg::CMD_SLOT_END, '0, '1));
    endtask

    task automatic test_knob_slew();
        send_command(make_command(ssps_pkg::CMD_LOAD_KNOBS, '1, '1));
        repeat (4) send_command(make_command(ssps_pkg::CMD_SLEW, '0, '0));
        send_command(make_command(ssps_pkg::CMD_LOAD_KNOBS, '0, '0));
        repeat (2) send_command(make_command(ssps_pkg::CMD_SLEW, '1, '0));
    endtask

    // Safe widths sit next to the current widths so homing ends in one round,
    // and a zero frame length forces the gap to saturate.
    task automatic test_homing_and_gap();
        drain_block();
        // Frame length first, then safe widths five down to one.
        program_registers({16'd0, 16'd10, 16'd5, 16'd0, 16'd30, 16'd30});
        send_command(make_command(ssps_pkg::CMD_HOME, '1, '1));
        send_command(make_command(ssps_pkg::CMD_HOME, '0, '0));
        repeat (NSERVO) send_command(make_command(ssps_pkg::CMD_SLEW, '0, '1));
        repeat (NSERVO + 2) send_command(make_command(ssps_pkg::CMD_SLOT_END, '1, '0));
    endtask

    task automatic test_random_phases();
        logic [ssps_pkg::CFG_FRAME:0][FIELD_BITS-1:0] vals;
        int                                           sent;
        int                                           n;
        int                                           style;
        int                                           r;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            drain_block();
            style = (sent == 0) ? -1 : $urandom_range(0, 7);
            for (r = ssps_pkg::CFG_SAFE_1; r < ssps_pkg::CFG_FRAME; r++) begin
                if (style < 0) vals[r] = FIELD_BITS'(FIELD_MAX);
                else if (style == 0) vals[r] = FIELD_BITS'($urandom);
                else if (style == 1) vals[r] = $urandom_range(0, 1) ? FIELD_BITS'(FIELD_MAX) : '0;
                else vals[r] = near_value(pulse_w[r], 30);
            end
            case ($urandom_range(0, 3))
                0:       vals[ssps_pkg::CFG_FRAME] = '0;
                1:       vals[ssps_pkg::CFG_FRAME] = FIELD_BITS'(FIELD_MAX);
                2:       vals[ssps_pkg::CFG_FRAME] = FIELD_BITS'($urandom);
                default: vals[ssps_pkg::CFG_FRAME] = near_value(int'(last_frame_sum), 100);
            endcase
            if (style < 0) vals[ssps_pkg::CFG_FRAME] = FIELD_BITS'(FIELD_MAX);
            program_registers(vals);
            n = $urandom_range(40, 120);
            repeat (n) send_command(random_command());
            sent += n;
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_frame();
        test_knob_slew();
        test_homing_and_gap();
        test_random_phases();
        drain_block();
        if (pending_results.size() != 0) begin
            report_failure($sformatf("%0d expected results never arrived",
                                     pending_results.size()));
        end
        $display("Checked %0d results from %0d commands over %0d register settings.",
                 results_checked, items_sent, settings_used);
        $display("Homing finished %0d times; %0d frame gaps were timed; %0d failures.",
                 homing_completions, gap_slots, failures);
        if (failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout: the run did not complete.");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
